[src/pfd_pkg.sv]
// Shared constants, types and saturation helpers for the filtered-derivative PID block.
package pfd_pkg;

	localparam int DataW    = 32;
	localparam int FracBits = 16;
	localparam int PeriodW  = 31;
	localparam int CfgIdxW  = 3;
	localparam int OpW      = DataW + 1;
	localparam int ProdW    = 2 * OpW;
	localparam int DivBits  = DataW + 1 + FracBits;
	localparam int DivCntW  = $clog2(DivBits + 1);

	typedef logic signed [DataW-1:0] word_t;
	typedef logic signed [ProdW-1:0] wide_t;

	localparam word_t WordMax = {1'b0, {(DataW-1){1'b1}}};
	localparam word_t WordMin = {1'b1, {(DataW-1){1'b0}}};
	localparam word_t One     = word_t'(1) <<< FracBits;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_PROP_GAIN     = 3'd0,
		CFG_INTEG_GAIN    = 3'd1,
		CFG_DERIV_GAIN    = 3'd2,
		CFG_INTEG_FLOOR   = 3'd3,
		CFG_INTEG_CEILING = 3'd4,
		CFG_FILTER_WEIGHT = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_P,
		S_I1,
		S_I2,
		S_I3,
		S_I4,
		S_DIV,
		S_M1,
		S_M2,
		S_M3,
		S_D,
		S_R,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic               done;
		logic [DivBits-1:0] quot;
	} div_res_t;

	// saturate a wide signed value to one data word
	function automatic word_t sat_w(input wide_t x);
		logic [ProdW-DataW:0] top;
		top = x[ProdW-1:DataW-1];
		if (&top || ~|top) begin
			return x[DataW-1:0];
		end
		return x[ProdW-1] ? WordMin : WordMax;
	endfunction

	function automatic wide_t sext(input word_t v);
		return {{(ProdW-DataW){v[DataW-1]}}, v};
	endfunction

endpackage

[src/pfd_if.sv]
// Valid/ready channel interfaces for the sample and result items.
interface pfd_sample_if
	import pfd_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [DataW-1:0]    target_value;
	logic signed [DataW-1:0]    sensed_value;
	logic        [PeriodW-1:0]  period;

	modport source(output valid, target_value, sensed_value, period, input ready);
	modport sink(input valid, target_value, sensed_value, period, output ready);
endinterface

interface pfd_result_if
	import pfd_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [DataW-1:0] drive;

	modport source(output valid, drive, input ready);
	modport sink(input valid, drive, output ready);
endinterface

[src/pfd_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned dividend by the period.
module pfd_div
	import pfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DivBits-1:0] dividend,
	input  logic [PeriodW-1:0] divisor,
	output div_res_t           res
);

	logic [PeriodW-1:0] rem_q;
	logic [DivBits-1:0] quo_q;
	logic [PeriodW-1:0] dvs_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [PeriodW:0]   trial;
	logic [PeriodW:0]   diff;
	logic               ge;

	assign trial = {rem_q, quo_q[DivBits-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DivCntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits the period width
			rem_q <= ge ? diff[PeriodW-1:0] : trial[PeriodW-1:0];
			quo_q <= {quo_q[DivBits-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;

endmodule

[src/pid_filtered_derivative.sv]
// PID controller with low-pass filtered derivative: sequencer, shared multiplier, state.
//
//  channel | dir | handshake     | payload
//  sample  | in  | valid/ready   | target_value, sensed_value, period
//  result  | out | valid/ready   | drive
//  cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// Each item takes the idle cycle, 12 sequencer steps around one shared 33x33 multiplier
// and a wait on the bit-serial slope divider (49 quotient bits plus its done strobe).
// A zero period goes from the error step straight to emit, with a zero drive.
// sample.ready is high only in the idle state.
// The result register holds a finished item while the next one is taken and worked on.
// Reset clears the integrator, previous error, filtered slope, gains and result valid.
module pid_filtered_derivative
	import pfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	pfd_sample_if.sink         sample,
	pfd_result_if.source       result,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_data
);

	state_t state_q, state_d;

	word_t kp_q, ki_q, kd_q, floor_q, ceil_q, fw_q;
	word_t acc_q, last_q, slope_q;
	word_t sp_q, ms_q, err_q, p_q, t_q, raw_q, res_q, drive_q;
	logic [PeriodW-1:0] dt_q;
	wide_t prod_q, sum_q;
	logic  out_valid_q, div_neg_q;

	logic signed [OpW-1:0] mul_a, mul_b;
	wide_t                 mul_p;
	logic                  out_free;
	logic                  div_start;
	div_res_t              div_res;

	logic signed [DataW:0] err_wide, diff;
	logic [DataW:0]        diff_mag;
	logic signed [OpW-1:0] wgt, wgt_c;
	word_t                 inc, acc_sum, d_term;
	logic signed [DataW+1:0] res_sum;
	logic signed [DivBits:0] raw_s;

	assign out_free = !out_valid_q || result.ready;
	assign mul_p    = mul_a * mul_b;

	assign err_wide = {sp_q[DataW-1], sp_q} - {ms_q[DataW-1], ms_q};
	assign diff     = {err_q[DataW-1], err_q} - {last_q[DataW-1], last_q};
	assign diff_mag = diff[DataW] ? (DataW+1)'(0) - diff : diff;

	always_comb begin
		if (fw_q[DataW-1]) begin
			wgt = '0;
		end else if (fw_q > One) begin
			wgt = {1'b0, One};
		end else begin
			wgt = {1'b0, fw_q};
		end
		wgt_c = {1'b0, One} - wgt;
	end

	assign inc     = sat_w(prod_q >>> FracBits);
	assign acc_sum = sat_w(sext(acc_q) + sext(inc));
	assign d_term  = sat_w(prod_q >>> FracBits);
	assign res_sum = {{2{p_q[DataW-1]}}, p_q} + {{2{acc_q[DataW-1]}}, acc_q}
		+ {{2{d_term[DataW-1]}}, d_term};
	assign raw_s   = div_neg_q ? -$signed({1'b0, div_res.quot}) : $signed({1'b0, div_res.quot});

	pfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({diff_mag, {FracBits{1'b0}}}),
		.divisor  (dt_q),
		.res      (div_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (sample.valid) state_d = S_ERR;
			S_ERR:  state_d = (dt_q == '0) ? S_EMIT : S_P;
			S_P:    state_d = S_I1;
			S_I1:   state_d = S_I2;
			S_I2:   state_d = S_I3;
			S_I3:   state_d = S_I4;
			S_I4:   state_d = S_DIV;
			S_DIV:  if (div_res.done) state_d = S_M1;
			S_M1:   state_d = S_M2;
			S_M2:   state_d = S_M3;
			S_M3:   state_d = S_D;
			S_D:    state_d = S_R;
			S_R:    state_d = S_EMIT;
			S_EMIT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: handshake, multiplier operands, divider start
	always_comb begin
		sample.ready = 1'b0;
		div_start    = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		unique case (state_q)
			S_IDLE: sample.ready = 1'b1;
			S_P: begin
				mul_a = OpW'(kp_q);
				mul_b = OpW'(err_q);
			end
			S_I1: begin
				mul_a = OpW'(ki_q);
				mul_b = OpW'(err_q);
			end
			S_I3: begin
				mul_a = OpW'(t_q);
				mul_b = $signed({2'b00, dt_q});
			end
			S_I4: div_start = 1'b1;
			S_M1: begin
				mul_a = wgt;
				mul_b = OpW'(raw_q);
			end
			S_M2: begin
				mul_a = wgt_c;
				mul_b = OpW'(slope_q);
			end
			S_D: begin
				mul_a = OpW'(kd_q);
				mul_b = OpW'(slope_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			floor_q     <= -(One >>> 1);
			ceil_q      <= One >>> 1;
			fw_q        <= One;
			acc_q       <= '0;
			last_q      <= '0;
			slope_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_PROP_GAIN:     kp_q    <= cfg_data;
					CFG_INTEG_GAIN:    ki_q    <= cfg_data;
					CFG_DERIV_GAIN:    kd_q    <= cfg_data;
					CFG_INTEG_FLOOR:   floor_q <= cfg_data;
					CFG_INTEG_CEILING: ceil_q  <= cfg_data;
					CFG_FILTER_WEIGHT: fw_q    <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_I4) begin
				// floor is tested first, so it wins over the ceiling for sums below the floor
				if (acc_sum < floor_q) begin
					acc_q <= floor_q;
				end else if (acc_sum > ceil_q) begin
					acc_q <= ceil_q;
				end else begin
					acc_q <= acc_sum;
				end
			end
			if (state_q == S_M3) slope_q <= sat_w((sum_q + prod_q) >>> FracBits);
			if (state_q == S_R) last_q <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			S_IDLE: begin
				sp_q <= sample.target_value;
				ms_q <= sample.sensed_value;
				dt_q <= sample.period;
			end
			S_ERR: begin
				err_q <= sat_w({{(ProdW-DataW-1){err_wide[DataW]}}, err_wide});
				res_q <= '0;
			end
			S_I1: p_q <= sat_w(prod_q >>> FracBits);
			S_I2: t_q <= sat_w(prod_q >>> FracBits);
			S_I4: div_neg_q <= diff[DataW];
			S_DIV: raw_q <= sat_w({{(ProdW-DivBits-1){raw_s[DivBits]}}, raw_s});
			S_M2: sum_q <= prod_q;
			S_R: res_q <= sat_w({{(ProdW-DataW-2){res_sum[DataW+1]}}, res_sum});
			S_EMIT: if (out_free) drive_q <= res_q;
			default: ;
		endcase
	end

	assign result.valid = out_valid_q;
	assign result.drive = drive_q;

endmodule
